@@ sv/slip_frame_encoder_defines.svh @@
// Assertion macros for the slip_frame_encoder RTL, included by sfe_ser.
// No dependencies; compiled away when SYNTHESIS is defined.
`ifndef SLIP_FRAME_ENCODER_DEFINES_SVH
`define SLIP_FRAME_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every clk edge out of reset
`define SFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ sv/sfe_pkg.sv @@
// Shared types and constants for the SLIP frame encoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package sfe_pkg;

	localparam int unsigned LenOverhead   = 4;
	localparam int unsigned ZeroFrameSize = 2;
	localparam int unsigned MaxResults    = 4;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_CAPACITY      = 3'd0,
		CFG_BOUNDARY      = 3'd1,
		CFG_ESCAPE        = 3'd2,
		CFG_BOUNDARY_SUB  = 3'd3,
		CFG_ESCAPE_SUB    = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [15:0] capacity;
		logic [7:0]  boundary_byte;
		logic [7:0]  escape_byte;
		logic [7:0]  boundary_substitute;
		logic [7:0]  escape_substitute;
	} cfg_t;

	// one output byte with its flags
	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       frame_error;
	} entry_t;

	// all results caused by one input item
	typedef struct packed {
		entry_t [MaxResults-1:0] ent;
		logic [2:0]              cnt;
		logic [15:0]             frame_size;
	} bundle_t;

endpackage

@@ sv/sfe_cfg.sv @@
// Configuration register file of the SLIP frame encoder.
// Depends on sfe_pkg for the register indexes and cfg_t.
`timescale 1ns / 1ps

module sfe_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output sfe_pkg::cfg_t       cfg
);

	sfe_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity            <= 16'd256;
			cfg_q.boundary_byte       <= 8'd192;
			cfg_q.escape_byte         <= 8'd219;
			cfg_q.boundary_substitute <= 8'd220;
			cfg_q.escape_substitute   <= 8'd221;
		end else if (cfg_valid) begin
			unique case (sfe_pkg::cfg_index_t'(cfg_index))
				sfe_pkg::CFG_CAPACITY:     cfg_q.capacity            <= cfg_data;
				sfe_pkg::CFG_BOUNDARY:     cfg_q.boundary_byte       <= cfg_data[7:0];
				sfe_pkg::CFG_ESCAPE:       cfg_q.escape_byte         <= cfg_data[7:0];
				sfe_pkg::CFG_BOUNDARY_SUB: cfg_q.boundary_substitute <= cfg_data[7:0];
				sfe_pkg::CFG_ESCAPE_SUB:   cfg_q.escape_substitute   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

@@ sv/sfe_core.sv @@
// Input register, frame state and byte-stuffing logic of the SLIP encoder.
// Builds the full result bundle for one item per cycle unless the output register holds it back; depends on sfe_pkg.
`timescale 1ns / 1ps

module sfe_core (
	input  logic             clk,
	input  logic             arst_n,
	input  sfe_pkg::cfg_t    cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       data_byte,
	input  logic [15:0]      packet_length,
	input  logic             first_item,
	input  logic             last_item,
	input  logic             load_ready,
	output logic             load,
	output sfe_pkg::bundle_t bundle
);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic [15:0] len_s1;
	logic        first_s1;
	logic        last_s1;

	logic [15:0] write_position_q;
	logic        in_frame_q;
	logic        frame_aborted_q;

	logic [15:0] nxt_wp;
	logic        nxt_in_frame;
	logic        nxt_aborted;
	logic        consume;

	// stage 1 moves on when its results are handed over or when it has none
	assign consume  = valid_s1 && ((bundle.cnt == 3'd0) || load_ready);
	assign load     = valid_s1 && (bundle.cnt != 3'd0) && load_ready;
	assign in_ready = !valid_s1 || consume;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1  <= data_byte;
			len_s1   <= packet_length;
			first_s1 <= first_item;
			last_s1  <= last_item;
		end
	end

	// frame state, updated as each item is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_position_q <= '0;
			in_frame_q       <= 1'b0;
			frame_aborted_q  <= 1'b0;
		end else if (consume) begin
			write_position_q <= nxt_wp;
			in_frame_q       <= nxt_in_frame;
			frame_aborted_q  <= nxt_aborted;
		end
	end

	// stuffing and fit checks for the item in stage 1
	always_comb begin
		logic [16:0] len_chk;
		logic [16:0] cap_ext;
		logic [16:0] fit_chk;
		logic [15:0] wp_use;
		logic [1:0]  need;
		logic [2:0]  n;
		logic        go;
		logic        is_bnd;
		logic        is_esc;

		bundle       = '0;
		n            = 3'd0;
		go           = 1'b0;
		wp_use       = write_position_q;
		nxt_wp       = write_position_q;
		nxt_in_frame = in_frame_q;
		nxt_aborted  = frame_aborted_q;
		cap_ext      = {1'b0, cfg.capacity};
		len_chk      = {1'b0, len_s1} + 17'(sfe_pkg::LenOverhead);
		is_bnd       = (data_s1 == cfg.boundary_byte);
		is_esc       = (data_s1 == cfg.escape_byte);
		need         = (is_bnd || is_esc) ? 2'd2 : 2'd1;

		if (first_s1) begin
			nxt_in_frame = 1'b0;
			nxt_aborted  = 1'b0;
			nxt_wp       = '0;
			if (len_chk > cap_ext) begin
				// packet can never fit: single error result
				bundle.ent[n[1:0]].frame_error = 1'b1;
				n            = n + 3'd1;
				nxt_in_frame = !last_s1;
				nxt_aborted  = !last_s1;
			end else begin
				bundle.ent[n[1:0]].out_byte = cfg.boundary_byte;
				n = n + 3'd1;
				if (len_s1 == 16'd0) begin
					// empty packet: open and close at once
					bundle.ent[n[1:0]].out_byte  = cfg.boundary_byte;
					bundle.ent[n[1:0]].frame_end = 1'b1;
					bundle.frame_size            = 16'(sfe_pkg::ZeroFrameSize);
					n = n + 3'd1;
				end else begin
					nxt_in_frame = 1'b1;
					go           = 1'b1;
					wp_use       = 16'd1;
				end
			end
		end else if (in_frame_q) begin
			if (frame_aborted_q) begin
				if (last_s1) begin
					nxt_in_frame = 1'b0;
					nxt_aborted  = 1'b0;
					nxt_wp       = '0;
				end
			end else begin
				go = 1'b1;
			end
		end

		fit_chk = {1'b0, wp_use} + {15'd0, need} + 17'd1;
		if (go) begin
			if (fit_chk > cap_ext) begin
				// stuffed byte plus closing boundary would overrun
				bundle.ent[n[1:0]].frame_error = 1'b1;
				n            = n + 3'd1;
				nxt_wp       = '0;
				nxt_in_frame = !last_s1;
				nxt_aborted  = !last_s1;
			end else begin
				if (is_bnd || is_esc) begin
					bundle.ent[n[1:0]].out_byte = cfg.escape_byte;
					n = n + 3'd1;
					bundle.ent[n[1:0]].out_byte = is_bnd ? cfg.boundary_substitute
						: cfg.escape_substitute;
					n = n + 3'd1;
				end else begin
					bundle.ent[n[1:0]].out_byte = data_s1;
					n = n + 3'd1;
				end
				nxt_wp = wp_use + {14'd0, need};
				if (last_s1) begin
					bundle.ent[n[1:0]].out_byte  = cfg.boundary_byte;
					bundle.ent[n[1:0]].frame_end = 1'b1;
					bundle.frame_size            = fit_chk[15:0];
					n            = n + 3'd1;
					nxt_wp       = '0;
					nxt_in_frame = 1'b0;
					nxt_aborted  = 1'b0;
				end
			end
		end
		bundle.cnt = n;
	end

endmodule

@@ sv/sfe_ser.sv @@
// Output register of the SLIP encoder: holds one result bundle and sends
// its bytes one per transaction. Depends on sfe_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "slip_frame_encoder_defines.svh"

module sfe_ser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sfe_pkg::bundle_t bundle,
	output logic             load_ready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,
	output logic             m_tlast,
	output logic [1:0]       m_tuser
);

	sfe_pkg::entry_t [sfe_pkg::MaxResults-1:0] ent_q;
	logic [2:0]  cnt_q;
	logic [15:0] size_q;
	logic [1:0]  idx_q;
	logic        busy_q;

	sfe_pkg::entry_t cur;
	logic            at_last;
	logic            take;

	assign cur        = ent_q[idx_q];
	assign at_last    = ({1'b0, idx_q} + 3'd1) == cnt_q;
	assign take       = busy_q && m_tready;
	assign load_ready = !busy_q || (m_tready && at_last);

	assign m_tvalid = busy_q;
	assign m_tlast  = at_last;
	assign m_tdata  = {cur.frame_end ? size_q : 16'd0, cur.out_byte};
	assign m_tuser  = {cur.frame_error, cur.frame_end};

	// control: busy flag and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// bundle payload
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q  <= bundle.ent;
			cnt_q  <= bundle.cnt;
			size_q <= bundle.frame_size;
		end
	end

	`SFE_ASSERT_NOW(a_reload_only_at_end, clk, arst_n, load && busy_q, take && at_last,
		"bundle reloaded before the last byte was taken")
	`SFE_ASSERT_NOW(a_idx_in_range, clk, arst_n, busy_q, 3'(idx_q) < cnt_q,
		"read index beyond bundle count")
	`SFE_ASSERT_NOW(a_error_is_last, clk, arst_n, m_tvalid && m_tuser[1], m_tlast,
		"error result is not the last of its item")
	`SFE_ASSERT_NOW(a_end_is_last, clk, arst_n, m_tvalid && m_tuser[0], m_tlast,
		"closing boundary is not the last of its item")
	`SFE_ASSERT_NEXT(a_load_makes_busy, clk, arst_n, load, busy_q && idx_q == 2'd0,
		"loaded bundle not presented from its first byte")

endmodule

@@ sv/slip_frame_encoder.sv @@
// SLIP frame encoder with byte stuffing. Each accepted payload byte yields up
// to four output bytes (opening boundary, escape pair or copy, closing
// boundary with frame size), a single error transaction when the frame does
// not fit in capacity, or none outside an open frame or in an aborted one.
// Items pass an input register; results are built combinationally and handed
// to an output register that sends them one byte per cycle while m_tready is
// high; a new item is accepted while the previous one is still being sent.
// The one-byte output port limits the flow: it sends an item's results one
// after another, and items that produce no result do not occupy it.
// Depends on sfe_pkg, sfe_cfg, sfe_core and sfe_ser.
`timescale 1ns / 1ps

module slip_frame_encoder (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] packet_length
	input  logic        s_tlast,   // last_item
	input  logic        s_tuser,   // first_item
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] frame_size
	output logic        m_tlast,   // run_last
	output logic [1:0]  m_tuser,   // [0] frame_end, [1] frame_error
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	sfe_pkg::cfg_t    cfg;
	sfe_pkg::bundle_t bundle;
	logic             load;
	logic             load_ready;

	sfe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfe_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.data_byte     (s_tdata[7:0]),
		.packet_length (s_tdata[23:8]),
		.first_item    (s_tuser),
		.last_item     (s_tlast),
		.load_ready    (load_ready),
		.load          (load),
		.bundle        (bundle)
	);

	sfe_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.bundle     (bundle),
		.load_ready (load_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule
